// File: rtl/cia_pkg.sv
package cia_pkg;

	localparam int unsigned DataWidth = 64;
	localparam int unsigned DivSteps  = 64;

	typedef logic [DataWidth-1:0] word_t;

	typedef enum logic [3:0] {
		OP_ADD  = 4'd0,
		OP_SUB  = 4'd1,
		OP_MUL  = 4'd2,
		OP_DIV  = 4'd3,
		OP_REM  = 4'd4,
		OP_AND  = 4'd5,
		OP_OR   = 4'd6,
		OP_XOR  = 4'd7,
		OP_NEG  = 4'd8,
		OP_NOT  = 4'd9,
		OP_ABS  = 4'd10,
		OP_EVEN = 4'd11,
		OP_ODD  = 4'd12,
		OP_EQ   = 4'd13,
		OP_GE   = 4'd14,
		OP_GT   = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OVF     = 2'd1,
		ST_ZDIV    = 2'd2,
		ST_INEXACT = 2'd3
	} status_t;

	// information that rides along with each transaction
	typedef struct packed {
		op_t     op;
		logic    neg_a;
		logic    neg_b;
		logic    b_zero;
		logic    b_m1;
		logic    a_min;
		word_t   value;
		status_t status;
	} side_t;

	// restoring divider state: partial remainder, shifting dividend/quotient, divisor
	typedef struct packed {
		word_t r;
		word_t q;
		word_t d;
	} div_t;

endpackage

// File: rtl/cia_mul.sv
module cia_mul (
	input  logic               clk,
	input  cia_pkg::word_t     x,
	input  cia_pkg::word_t     y,
	output cia_pkg::word_t     hi,
	output cia_pkg::word_t     lo
);

	cia_pkg::word_t p00_s1, p01_s1, p10_s1, p11_s1;
	cia_pkg::word_t hi_s2, lo_s2;
	logic [33:0]    mid;

	always_ff @(posedge clk) begin
		p00_s1 <= {32'd0, x[31:0]}  * {32'd0, y[31:0]};
		p01_s1 <= {32'd0, x[31:0]}  * {32'd0, y[63:32]};
		p10_s1 <= {32'd0, x[63:32]} * {32'd0, y[31:0]};
		p11_s1 <= {32'd0, x[63:32]} * {32'd0, y[63:32]};
	end

	assign mid = {2'b00, p00_s1[63:32]} + {2'b00, p01_s1[31:0]} + {2'b00, p10_s1[31:0]};

	always_ff @(posedge clk) begin
		lo_s2 <= {mid[31:0], p00_s1[31:0]};
		hi_s2 <= p11_s1 + {32'd0, p01_s1[63:32]} + {32'd0, p10_s1[63:32]}
			+ {62'd0, mid[33:32]};
	end

	assign hi = hi_s2;
	assign lo = lo_s2;

endmodule

// File: rtl/cia_div_step.sv
module cia_div_step (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  cia_pkg::side_t in_side,
	input  cia_pkg::div_t  in_div,
	output logic           out_valid,
	output cia_pkg::side_t out_side,
	output cia_pkg::div_t  out_div
);

	logic           valid_s1;
	cia_pkg::side_t side_s1;
	cia_pkg::div_t  div_s1;
	logic [64:0]    trial;
	logic [65:0]    diff;
	logic           fits;

	// one quotient bit per stage
	assign trial = {in_div.r, in_div.q[63]};
	assign diff  = {1'b0, trial} - {2'b00, in_div.d};
	assign fits  = ~diff[65];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		side_s1  <= in_side;
		div_s1.d <= in_div.d;
		div_s1.q <= {in_div.q[62:0], fits};
		div_s1.r <= fits ? diff[63:0] : trial[63:0];
	end

	assign out_valid = valid_s1;
	assign out_side  = side_s1;
	assign out_div   = div_s1;

endmodule

// File: rtl/checked_int64_alu.sv
// checked signed 64-bit alu, fully pipelined
// input: a transaction is taken at each rising edge with start high and busy low;
// req_type selects the operation, operand_a and operand_b are two's complement
// busy is held low: the pipeline takes a new transaction every cycle
// output: done is high for one cycle with value and status; value is zero
// whenever status is not ok
// order: every operation passes through all the same stages,
// so results leave in the order the transactions came in
// the stages are an input stage, three stages that form and check the
// 128-bit product from four 32x32 partials, 64 stages of the restoring divider
// with one quotient bit each, and an output register
// throughput: one transaction per cycle, back to back, with no gaps
// reset: arst_n clears all valid bits at once; transactions in flight are dropped
// the receiver cannot stall, so no result is ever held back
module checked_int64_alu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  req_type,
	input  logic [63:0] operand_a,
	input  logic [63:0] operand_b,
	output logic        done,
	output logic [63:0] value,
	output logic [1:0]  status
);

	localparam cia_pkg::word_t MinWord = {1'b1, 63'd0};

	cia_pkg::op_t   op;
	cia_pkg::side_t side_in;
	cia_pkg::word_t mag_a, mag_b;
	logic [63:0]    sum;
	logic [63:0]    dif;

	logic           valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	cia_pkg::side_t side_s1, side_s2, side_s3, side_s4;
	cia_pkg::side_t side_mul;
	cia_pkg::word_t ma_s1, mb_s1, ma_s2, mb_s2, ma_s3, mb_s3;
	cia_pkg::div_t  div_s4;
	cia_pkg::word_t mul_hi, mul_lo;
	cia_pkg::word_t value_s5;
	cia_pkg::status_t status_s5;

	logic           chain_valid [0:cia_pkg::DivSteps];
	cia_pkg::side_t chain_side  [0:cia_pkg::DivSteps];
	cia_pkg::div_t  chain_div   [0:cia_pkg::DivSteps];

	assign busy = 1'b0;
	assign op   = cia_pkg::op_t'(req_type);

	assign mag_a = operand_a[63] ? (64'd0 - operand_a) : operand_a;
	assign mag_b = operand_b[63] ? (64'd0 - operand_b) : operand_b;
	assign sum   = operand_a + operand_b;
	assign dif   = operand_a - operand_b;

	// stage 1: everything but mul, div and rem finishes here
	always_comb begin
		side_in.op     = op;
		side_in.neg_a  = operand_a[63];
		side_in.neg_b  = operand_b[63];
		side_in.b_zero = (operand_b == 64'd0);
		side_in.b_m1   = (operand_b == {64{1'b1}});
		side_in.a_min  = (operand_a == MinWord);
		side_in.value  = 64'd0;
		side_in.status = cia_pkg::ST_OK;
		unique case (op)
			cia_pkg::OP_ADD: begin
				side_in.value = sum;
				if (operand_a[63] == operand_b[63] && sum[63] != operand_a[63])
					side_in.status = cia_pkg::ST_OVF;
			end
			cia_pkg::OP_SUB: begin
				side_in.value = dif;
				if (operand_a[63] != operand_b[63] && dif[63] != operand_a[63])
					side_in.status = cia_pkg::ST_OVF;
			end
			cia_pkg::OP_AND: side_in.value = operand_a & operand_b;
			cia_pkg::OP_OR:  side_in.value = operand_a | operand_b;
			cia_pkg::OP_XOR: side_in.value = operand_a ^ operand_b;
			cia_pkg::OP_NEG: begin
				if (operand_a == MinWord) side_in.status = cia_pkg::ST_OVF;
				else side_in.value = 64'd0 - operand_a;
			end
			cia_pkg::OP_NOT: side_in.value = ~operand_a;
			cia_pkg::OP_ABS: begin
				if (operand_a == MinWord) side_in.status = cia_pkg::ST_OVF;
				else side_in.value = mag_a;
			end
			cia_pkg::OP_EVEN: side_in.value = {63'd0, ~operand_a[0]};
			cia_pkg::OP_ODD:  side_in.value = {63'd0, operand_a[0]};
			cia_pkg::OP_EQ:   side_in.value = {63'd0, operand_a == operand_b};
			cia_pkg::OP_GE:
				side_in.value = {63'd0, $signed(operand_a) >= $signed(operand_b)};
			cia_pkg::OP_GT:
				side_in.value = {63'd0, $signed(operand_a) > $signed(operand_b)};
			default: side_in.value = 64'd0;
		endcase
		if (side_in.status != cia_pkg::ST_OK)
			side_in.value = 64'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		ma_s1   <= mag_a;
		mb_s1   <= mag_b;
		side_s2 <= side_s1;
		ma_s2   <= ma_s1;
		mb_s2   <= mb_s1;
		side_s3 <= side_s2;
		ma_s3   <= ma_s2;
		mb_s3   <= mb_s2;
	end

	cia_mul u_mul (
		.clk (clk),
		.x   (ma_s1),
		.y   (mb_s1),
		.hi  (mul_hi),
		.lo  (mul_lo)
	);

	// stage 4: range check and sign of the product
	always_comb begin
		side_mul = side_s3;
		if (side_s3.op == cia_pkg::OP_MUL) begin
			if (mul_hi != 64'd0 || ((side_s3.neg_a ^ side_s3.neg_b) ? (mul_lo > MinWord)
				: (mul_lo >= MinWord))) begin
				side_mul.value  = 64'd0;
				side_mul.status = cia_pkg::ST_OVF;
			end else begin
				side_mul.value  = (side_s3.neg_a ^ side_s3.neg_b) ? (64'd0 - mul_lo) : mul_lo;
				side_mul.status = cia_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s4  <= side_mul;
		div_s4.r <= 64'd0;
		div_s4.q <= ma_s3;
		div_s4.d <= mb_s3;
	end

	assign chain_valid[0] = valid_s4;
	assign chain_side[0]  = side_s4;
	assign chain_div[0]   = div_s4;

	for (genvar i = 0; i < cia_pkg::DivSteps; i++) begin : g_div
		cia_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_valid[i]),
			.in_side   (chain_side[i]),
			.in_div    (chain_div[i]),
			.out_valid (chain_valid[i+1]),
			.out_side  (chain_side[i+1]),
			.out_div   (chain_div[i+1])
		);
	end

	cia_pkg::side_t last_side;
	cia_pkg::div_t  last_div;
	cia_pkg::word_t fin_mag;
	logic           fin_neg;
	cia_pkg::word_t fin_value;
	cia_pkg::status_t fin_status;

	assign last_side = chain_side[cia_pkg::DivSteps];
	assign last_div  = chain_div[cia_pkg::DivSteps];
	assign fin_mag   = (last_side.op == cia_pkg::OP_DIV) ? last_div.q : last_div.r;
	assign fin_neg   = (last_side.op == cia_pkg::OP_DIV) ? (last_side.neg_a ^ last_side.neg_b)
		: last_side.neg_a;

	always_comb begin
		fin_value  = last_side.value;
		fin_status = last_side.status;
		case (last_side.op)
			cia_pkg::OP_DIV: begin
				fin_value = 64'd0;
				if (last_side.b_zero) fin_status = cia_pkg::ST_ZDIV;
				else if (last_side.a_min && last_side.b_m1) fin_status = cia_pkg::ST_OVF;
				else if (last_div.r != 64'd0) fin_status = cia_pkg::ST_INEXACT;
				else begin
					fin_status = cia_pkg::ST_OK;
					fin_value  = fin_neg ? (64'd0 - fin_mag) : fin_mag;
				end
			end
			cia_pkg::OP_REM: begin
				fin_value  = 64'd0;
				fin_status = cia_pkg::ST_OK;
				if (last_side.b_zero) fin_status = cia_pkg::ST_ZDIV;
				else if (!last_side.b_m1) fin_value = fin_neg ? (64'd0 - fin_mag) : fin_mag;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= chain_valid[cia_pkg::DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		value_s5  <= fin_value;
		status_s5 <= fin_status;
	end

	assign done   = valid_s5;
	assign value  = value_s5;
	assign status = status_s5;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##69 done) else $error("result missing after latency");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 69)) else $error("result without transaction");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != cia_pkg::ST_OK) |-> value == 64'd0)
		else $error("nonzero value with failing status");

	a_bool_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && (req_type == cia_pkg::OP_EQ || req_type == cia_pkg::OP_GE
			|| req_type == cia_pkg::OP_GT)) |-> ##69 (value[63:1] == 63'd0))
		else $error("compare gave non boolean value");

endmodule
